/* src/rft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rft_pkg;

	// Field widths fixed by the interface.
	localparam int BYTE_W    = 8;
	localparam int RAIL_W    = 7;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

	// Reset value of the rail count register.
	localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = 7'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // an input item is taken this cycle
		logic start;    // initialize the permutation walk
		logic perm;     // permutation walk is running
		logic emit_rd;  // read the next result byte
		logic emit_ld;  // load the output register
		logic clr;      // message finished, clear length and overflow
	} rft_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_done;  // every position has been permuted
		logic emit_last;  // the byte being emitted is the final one
		logic out_free;   // output register can take a byte this cycle
	} rft_sts_t;

endpackage

`default_nettype wire

/* src/rft_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/rft_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rft_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	input  wire rft_pkg::rft_sts_t sts,
	output rft_pkg::rft_cmd_t     cmd,
	output logic                  in_stall
);

	localparam logic [1:0] ST_LOAD    = 2'd0;
	localparam logic [1:0] ST_PERM    = 2'd1;
	localparam logic [1:0] ST_EMIT_RD = 2'd2;
	localparam logic [1:0] ST_EMIT_WR = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Input items are taken only while a message is being loaded.
	assign in_stall = (state_q != ST_LOAD);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.accept = in_valid;
				if (in_valid && in_last) begin
					cmd.start = 1'b1;
					state_d   = ST_PERM;
				end
			end
			ST_PERM: begin
				cmd.perm = 1'b1;
				if (sts.walk_done) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					if (sts.emit_last) begin
						cmd.clr = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// The walk only leaves toward emitting.
	a_perm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PERM |=> state_q == ST_PERM || state_q == ST_EMIT_RD)
		else $error("permutation walk left to an unexpected state");

	// Emitting the final byte returns to loading.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld && sts.emit_last |=> state_q == ST_LOAD)
		else $error("final byte emitted but controller did not return to load");

	// A new message starts only from the load state.
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == ST_LOAD && in_valid)
		else $error("walk started outside of loading");

endmodule

`default_nettype wire

/* src/rft_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module rft_dp #(
	parameter int MAX_LEN = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [rft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rft_pkg::RAIL_W-1:0]      cfg_data,
	input  wire logic [rft_pkg::BYTE_W-1:0]      in_byte,
	input  wire rft_pkg::rft_cmd_t               cmd,
	output rft_pkg::rft_sts_t                    sts,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic      [rft_pkg::BYTE_W-1:0]      out_byte,
	output logic                                 out_last,
	output logic                                 truncated
);

	localparam int AW   = $clog2(MAX_LEN);
	localparam int LW   = $clog2(MAX_LEN + 1);
	localparam int PERW = rft_pkg::RAIL_W + 1;
	localparam int PW   = ((LW > PERW) ? LW : PERW) + 1;

	// Configuration registers.
	logic [rft_pkg::RAIL_W-1:0] rail_count_q;
	logic                       decrypt_q;

	// Message bookkeeping.
	logic [LW-1:0] len_q;
	logic          ovf_q;

	// Permutation walk state.
	logic [LW-1:0]              j_q;
	logic [rft_pkg::RAIL_W-1:0] rail_q;
	logic [PW-1:0]              pos_q;
	logic                       ph_q;
	logic                       wr_v_s1;
	logic [AW-1:0]              wr_addr_s1;

	// Emit counter and output register.
	logic [LW-1:0]              e_q;
	logic                       out_v_q;
	logic [rft_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;
	logic                       out_trunc_q;

	logic                       room;
	logic                       ident;
	logic                       edge_rail;
	logic [PERW-1:0]            period;
	logic [PERW-1:0]            two_k;
	logic [PERW-1:0]            step_a;
	logic [PERW-1:0]            step_b;
	logic                       hit;
	logic                       step;
	logic [rft_pkg::BYTE_W-1:0] store_rdata;
	logic [rft_pkg::BYTE_W-1:0] res_rdata;
	logic [AW-1:0]              store_raddr;

	assign room = (len_q < LW'(MAX_LEN));

	// Zigzag step sizes for the current rail: the top and bottom rails advance by
	// a whole period, inner rails alternate between the down and up legs; with at most one rail, every step is one.
	assign ident     = (rail_count_q <= rft_pkg::RAIL_W'(1));
	assign period    = {rail_count_q - rft_pkg::RAIL_W'(1), 1'b0};
	assign two_k     = {rail_q, 1'b0};
	assign edge_rail = (rail_q == '0) || (rail_q == rail_count_q - rft_pkg::RAIL_W'(1));

	always_comb begin
		if (ident) begin
			step_a = PERW'(1);
			step_b = PERW'(1);
		end else if (edge_rail) begin
			step_a = period;
			step_b = period;
		end else begin
			step_a = period - two_k;
			step_b = two_k;
		end
	end

	assign hit  = (pos_q < PW'(len_q));
	assign step = cmd.perm && !sts.walk_done;

	assign sts.walk_done = (j_q == len_q);
	assign sts.emit_last = (e_q == len_q - LW'(1));
	assign sts.out_free  = !out_v_q || !out_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_count_q <= rft_pkg::RAIL_COUNT_RESET;
			decrypt_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rft_pkg::REG_RAIL_COUNT:   rail_count_q <= cfg_data;
				rft_pkg::REG_DECRYPT_MODE: decrypt_q    <= cfg_data[0];
			endcase
		end
	end

	// Message length and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.accept) begin
			if (room) begin
				len_q <= len_q + LW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Walk the fence rail by rail; a position past the message moves to the next rail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			rail_q  <= '0;
			pos_q   <= '0;
			ph_q    <= 1'b0;
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= step && hit;
			if (cmd.start) begin
				j_q    <= '0;
				rail_q <= '0;
				pos_q  <= '0;
				ph_q   <= 1'b0;
			end else if (step) begin
				if (hit) begin
					j_q   <= j_q + LW'(1);
					pos_q <= pos_q + PW'(ph_q ? step_b : step_a);
					ph_q  <= !ph_q;
				end else begin
					rail_q <= rail_q + rft_pkg::RAIL_W'(1);
					pos_q  <= PW'(rail_q) + PW'(1);
					ph_q   <= 1'b0;
				end
			end
		end
	end

	// Result address: the fence order in decrypt mode, sequential in encrypt mode.
	always_ff @(posedge clk) begin
		wr_addr_s1 <= decrypt_q ? pos_q[AW-1:0] : j_q[AW-1:0];
	end

	assign store_raddr = decrypt_q ? j_q[AW-1:0] : pos_q[AW-1:0];

	rft_ram #(
		.WIDTH (rft_pkg::BYTE_W),
		.DEPTH (MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept && room),
		.waddr (len_q[AW-1:0]),
		.wdata (in_byte),
		.re    (step && hit),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	rft_ram #(
		.WIDTH (rft_pkg::BYTE_W),
		.DEPTH (MAX_LEN)
	) u_result (
		.clk   (clk),
		.we    (wr_v_s1),
		.waddr (wr_addr_s1),
		.wdata (store_rdata),
		.re    (cmd.emit_rd),
		.raddr (e_q[AW-1:0]),
		.rdata (res_rdata)
	);

	// Emit counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				e_q <= '0;
			end else if (cmd.emit_ld) begin
				e_q <= e_q + LW'(1);
			end
			if (cmd.emit_ld) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_byte_q  <= res_rdata;
			out_last_q  <= sts.emit_last;
			out_trunc_q <= ovf_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign truncated = out_trunc_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN))
		else $error("message length exceeds the buffer depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LW'(MAX_LEN))
		else $error("overflow flagged while the buffer is not full");

	a_rail_range: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> PW'(rail_q) < PW'(len_q))
		else $error("walk moved past the last rail holding message bytes");

endmodule

`default_nettype wire

/* src/rail_fence_transposition.sv */
// Channel   Signals                                      Direction   Moves
// input     in_valid, in_stall, in_byte, in_last         into block  one message byte
// output    out_valid, out_stall, out_byte, out_last,    out of block one permuted byte
//           truncated
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    into block  one register write
//
// Loading takes one item per cycle; an item without the last mark gives no result.
// After the last item the permutation walk steps through every message position and
// moves to the next rail past the end of the message; then each result byte passes
// through the registered read of the result memory. Input is stalled from the last
// item until the final result byte is in the output register; configuration writes
// are always taken. Reset clears all control state; the memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rail_fence_transposition #(
	parameter int MAX_LEN = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rft_pkg::BYTE_W-1:0]      in_byte,
	input  wire logic                            in_last,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [rft_pkg::BYTE_W-1:0]      out_byte,
	output logic                                 out_last,
	output logic                                 truncated,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rft_pkg::RAIL_W-1:0]      cfg_data
);

	rft_pkg::rft_cmd_t cmd;
	rft_pkg::rft_sts_t sts;

	// Register writes are never held off.
	assign cfg_ready = 1'b1;

	rft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	rft_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.truncated (truncated)
	);

endmodule

`default_nettype wire
